[rtl/pcpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and constants of the per-CPU page allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  localparam int NUM_REQ     = 8;
  localparam int NUM_PAGES   = 32768;
  localparam int STEAL_LIMIT = 64;

  localparam int REQ_W    = 3;
  localparam int IDX_W    = $clog2(NUM_PAGES);
  localparam int LINK_W   = IDX_W + 1;
  localparam int ADDR_W   = 32;
  localparam int PG_SHIFT = 12;
  localparam int PGNUM_W  = ADDR_W - PG_SHIFT;
  localparam int BUDGET_W = $clog2(STEAL_LIMIT + 1);
  localparam int VIC_W    = $clog2(NUM_REQ + 1);
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  // Configuration register indexes
  localparam logic CFG_REGION_START = 1'b0;
  localparam logic CFG_REGION_END   = 1'b1;

  // Actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
  } op_entry_t;

endpackage

[rtl/pcpa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_front
// Holds the region registers, classifies each transaction and queues it.
// ----------------------------------------------------------------------------
module pcpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pcpa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [pcpa_pkg::REQ_W-1:0]    in_requester,
  input  logic [pcpa_pkg::ADDR_W-1:0]   in_page_addr,
  output logic                          q_valid,
  output pcpa_pkg::op_entry_t           q_head,
  input  logic                          q_pop,
  output logic [pcpa_pkg::ADDR_W-1:0]   base
);

  logic [pcpa_pkg::ADDR_W-1:0]  region_start_r, region_end_r;
  pcpa_pkg::op_entry_t          q_mem_r [pcpa_pkg::Q_DEPTH];
  logic [pcpa_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pcpa_pkg::QCNT_W-1:0]  cnt_r;
  logic [pcpa_pkg::ADDR_W-1:0]  offset;
  logic                         bad;
  logic                         push;
  pcpa_pkg::op_entry_t          entry;

  function automatic logic [pcpa_pkg::QCNT_W-1:0] QCNT_INC(input logic b);
    QCNT_INC = pcpa_pkg::QCNT_W'(b);
  endfunction

  // Page base: region start rounded up to a page
  assign base = (region_start_r + pcpa_pkg::ADDR_W'(12'hFFF)) &
                ~pcpa_pkg::ADDR_W'(12'hFFF);
  assign offset = in_page_addr - base;

  // Classify the incoming transaction
  always_comb begin
    bad = ({1'b0, in_requester} >= (pcpa_pkg::REQ_W + 1)'(pcpa_pkg::NUM_REQ)) ||
          (in_page_addr[pcpa_pkg::PG_SHIFT-1:0] != '0) ||
          (in_page_addr < region_start_r) || (in_page_addr >= region_end_r) ||
          (offset[pcpa_pkg::ADDR_W-1:pcpa_pkg::PG_SHIFT] >=
           pcpa_pkg::PGNUM_W'(pcpa_pkg::NUM_PAGES));
    entry.req = in_requester;
    entry.idx = offset[pcpa_pkg::PG_SHIFT +: pcpa_pkg::IDX_W];
    if (in_action == pcpa_pkg::ACT_ALLOC) begin
      entry.kind = pcpa_pkg::OP_ALLOC;
    end else if (bad) begin
      entry.kind = pcpa_pkg::OP_BAD;
    end else begin
      entry.kind = pcpa_pkg::OP_FREE;
    end
  end

  assign busy    = (cnt_r == pcpa_pkg::QCNT_W'(pcpa_pkg::Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_end_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pcpa_pkg::CFG_REGION_START) begin
        region_start_r <= cfg_wdata;
      end else begin
        region_end_r <= cfg_wdata;
      end
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_INC(push) - QCNT_INC(q_pop && q_valid);
    end
  end

  // Store queued entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

[rtl/pcpa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_back
// Executes queued transactions on the free lists, including stealing.
// ----------------------------------------------------------------------------
module pcpa_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  pcpa_pkg::op_entry_t           q_head,
  output logic                          q_pop,
  input  logic [pcpa_pkg::ADDR_W-1:0]   base,
  output logic                          out_valid,
  output logic [pcpa_pkg::ADDR_W-1:0]   out_result_addr,
  output logic [1:0]                    out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEAL,
    S_STEAL_WAIT,
    S_POP_WAIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [pcpa_pkg::IDX_W-1:0]      head_r [pcpa_pkg::NUM_REQ];
  logic [pcpa_pkg::IDX_W-1:0]      head_nxt [pcpa_pkg::NUM_REQ];
  logic [pcpa_pkg::NUM_REQ-1:0]    ne_r, ne_nxt;
  logic [pcpa_pkg::REQ_W-1:0]      req_r, req_nxt;
  logic [pcpa_pkg::VIC_W-1:0]      vic_r, vic_nxt;
  logic [pcpa_pkg::BUDGET_W-1:0]   budget_r, budget_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pcpa_pkg::ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;

  logic [pcpa_pkg::LINK_W-1:0]     link_mem [pcpa_pkg::NUM_PAGES];
  logic [pcpa_pkg::LINK_W-1:0]     rd_data_r;
  logic                            mem_we, mem_re;
  logic [pcpa_pkg::IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [pcpa_pkg::LINK_W-1:0]     mem_wdata;
  logic [pcpa_pkg::REQ_W-1:0]      vic;

  assign vic = vic_r[pcpa_pkg::REQ_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    ne_nxt         = ne_r;
    req_nxt        = req_r;
    vic_nxt        = vic_r;
    budget_nxt     = budget_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = '0;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;
    mem_wdata      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_head.req;
          unique case (q_head.kind)
            pcpa_pkg::OP_BAD: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = pcpa_pkg::ST_BAD;
            end
            pcpa_pkg::OP_FREE: begin
              // Push the page onto the requester's list
              mem_we    = 1'b1;
              mem_waddr = q_head.idx;
              mem_wdata = ne_r[q_head.req] ? {1'b1, head_r[q_head.req]} : '0;
              head_nxt[q_head.req] = q_head.idx;
              ne_nxt[q_head.req]   = 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = pcpa_pkg::ST_FREED;
            end
            default: begin
              if ({1'b0, q_head.req} >= (pcpa_pkg::REQ_W + 1)'(pcpa_pkg::NUM_REQ)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pcpa_pkg::ST_OOM;
              end else if (ne_r[q_head.req]) begin
                mem_re    = 1'b1;
                mem_raddr = head_r[q_head.req];
                state_nxt = S_POP_WAIT;
              end else begin
                vic_nxt    = '0;
                budget_nxt = pcpa_pkg::BUDGET_W'(pcpa_pkg::STEAL_LIMIT);
                state_nxt  = S_STEAL;
              end
            end
          endcase
        end
      end
      S_STEAL: begin
        if (budget_r == '0 || vic_r == pcpa_pkg::VIC_W'(pcpa_pkg::NUM_REQ)) begin
          // Steal done: pop if anything arrived
          if (ne_r[req_r]) begin
            mem_re    = 1'b1;
            mem_raddr = head_r[req_r];
            state_nxt = S_POP_WAIT;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pcpa_pkg::ST_OOM;
            state_nxt      = S_IDLE;
          end
        end else if (vic == req_r || !ne_r[vic]) begin
          vic_nxt = vic_r + 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_r[vic];
          state_nxt = S_STEAL_WAIT;
        end
      end
      S_STEAL_WAIT: begin
        // Pop from the victim, push onto the requester
        if (rd_data_r[pcpa_pkg::LINK_W-1]) begin
          head_nxt[vic] = rd_data_r[pcpa_pkg::IDX_W-1:0];
        end else begin
          ne_nxt[vic] = 1'b0;
        end
        mem_we    = 1'b1;
        mem_waddr = head_r[vic];
        mem_wdata = ne_r[req_r] ? {1'b1, head_r[req_r]} : '0;
        head_nxt[req_r] = head_r[vic];
        ne_nxt[req_r]   = 1'b1;
        budget_nxt = budget_r - 1'b1;
        state_nxt  = S_STEAL;
      end
      S_POP_WAIT: begin
        if (rd_data_r[pcpa_pkg::LINK_W-1]) begin
          head_nxt[req_r] = rd_data_r[pcpa_pkg::IDX_W-1:0];
        end else begin
          ne_nxt[req_r] = 1'b0;
        end
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = base + (pcpa_pkg::ADDR_W'(head_r[req_r]) << pcpa_pkg::PG_SHIFT);
        out_status_nxt = pcpa_pkg::ST_ALLOC;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, list heads and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ne_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      out_valid_r <= out_valid_nxt;
    end
    head_r       <= head_nxt;
    req_r        <= req_nxt;
    vic_r        <= vic_nxt;
    budget_r     <= budget_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[mem_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

endmodule

[rtl/per_cpu_page_allocator_with_steal_core.sv]
`timescale 1ns / 1ps
// Flow: a free or bad free is answered straight from the queue head; an alloc
//   from the requester's own list first reads the link memory; an alloc that
//   steals scans the other requesters in turn and moves at most 64 pages first.
// Queue: the back end works on one transaction at a time; a 2-entry queue
//   accepts transactions meanwhile, then holds busy high.
// Reset: synchronous, active low; lists empty, region registers zero. The
//   receiver cannot stall, so results are never held off.
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_steal_core
// Per-requester LIFO page free lists with stealing on an empty list.
// ----------------------------------------------------------------------------
module per_cpu_page_allocator_with_steal_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pcpa_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [pcpa_pkg::REQ_W-1:0]    in_requester,
  input  logic [pcpa_pkg::ADDR_W-1:0]   in_page_addr,
  output logic                          out_valid,
  output logic [pcpa_pkg::ADDR_W-1:0]   out_result_addr,
  output logic [1:0]                    out_status
);

  logic                         q_valid, q_pop;
  pcpa_pkg::op_entry_t          q_head;
  logic [pcpa_pkg::ADDR_W-1:0]  base;

  pcpa_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
    .in_action, .in_requester, .in_page_addr,
    .q_valid, .q_head, .q_pop, .base
  );

  pcpa_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .base,
    .out_valid, .out_result_addr, .out_status
  );

endmodule

[rtl/pcpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pcpa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         busy,
  input logic                         out_valid,
  input logic [pcpa_pkg::ADDR_W-1:0]  out_result_addr,
  input logic [1:0]                   out_status
);

  // Non-alloc results carry a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pcpa_pkg::ST_ALLOC |-> out_result_addr == '0)
    else $error("nonzero address on non-alloc result");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // Not busy right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

  // Nothing out when reset was asserted just before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("spurious result");

endmodule

bind per_cpu_page_allocator_with_steal_core pcpa_checker u_pcpa_checker (
  .clk, .rst_n, .busy, .out_valid, .out_result_addr, .out_status
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator testbench
// Drives alloc and free transactions into the per-CPU page allocator under
// several region settings, predicts every result with a behavioral copy of
// the per-requester free lists (stealing included) and compares each result
// field by field as it comes out.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_CYCLES = 5000;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [pcpa_pkg::ADDR_W-1:0] addr;
    logic [1:0]                  status;
  } alloc_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [pcpa_pkg::ADDR_W-1:0] cfg_wdata;
  logic                        start;
  logic                        busy;
  logic                        in_action;
  logic [pcpa_pkg::REQ_W-1:0]  in_requester;
  logic [pcpa_pkg::ADDR_W-1:0] in_page_addr;
  logic                        out_valid;
  logic [pcpa_pkg::ADDR_W-1:0] out_result_addr;
  logic [1:0]                  out_status;

  per_cpu_page_allocator_with_steal_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_requester    (in_requester),
    .in_page_addr    (in_page_addr),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status)
  );

  // Free-list shadow state
  logic [pcpa_pkg::ADDR_W-1:0] region_lo;
  logic [pcpa_pkg::ADDR_W-1:0] region_hi;
  logic [pcpa_pkg::IDX_W-1:0]  head_page [pcpa_pkg::NUM_REQ];
  logic                        list_valid [pcpa_pkg::NUM_REQ];
  logic [pcpa_pkg::LINK_W-1:0] page_link [pcpa_pkg::NUM_PAGES];

  alloc_result_t pending_results [$];
  int            error_count;
  int            idle_cycles;
  int            burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Push a page onto a requester's list.
  function automatic void list_push(input int r, input logic [pcpa_pkg::IDX_W-1:0] idx);
    page_link[idx] = list_valid[r] ? {1'b1, head_page[r]} : '0;
    head_page[r]   = idx;
    list_valid[r]  = 1'b1;
  endfunction

  // Pop the head of a list that holds at least one page.
  function automatic logic [pcpa_pkg::IDX_W-1:0] list_pop(input int r);
    logic [pcpa_pkg::IDX_W-1:0] idx;
    idx = head_page[r];
    if (page_link[idx][pcpa_pkg::LINK_W-1]) head_page[r] = page_link[idx][pcpa_pkg::IDX_W-1:0];
    else list_valid[r] = 1'b0;
    return idx;
  endfunction

  // Compute the result of one transaction and update the lists.
  function automatic alloc_result_t predict_page_op(input logic act,
      input logic [pcpa_pkg::REQ_W-1:0] req, input logic [pcpa_pkg::ADDR_W-1:0] addr);
    alloc_result_t               res;
    logic [pcpa_pkg::ADDR_W-1:0] base;
    logic [pcpa_pkg::ADDR_W-1:0] offs;
    int                          budget;
    base = (region_lo + 32'hFFF) & ~32'hFFF;
    res.addr = '0;
    if (act == pcpa_pkg::ACT_FREE) begin
      offs = (addr - base) >> pcpa_pkg::PG_SHIFT;
      if (addr[pcpa_pkg::PG_SHIFT-1:0] != 0 || addr < region_lo || addr >= region_hi ||
          offs >= pcpa_pkg::NUM_PAGES) begin
        res.status = pcpa_pkg::ST_BAD;
      end else begin
        list_push(req, offs[pcpa_pkg::IDX_W-1:0]);
        res.status = pcpa_pkg::ST_FREED;
      end
      return res;
    end
    // Steal from the other lists in ascending order when empty.
    if (!list_valid[req]) begin
      budget = pcpa_pkg::STEAL_LIMIT;
      for (int v = 0; v < pcpa_pkg::NUM_REQ && budget != 0; v++) begin
        if (v == req) continue;
        while (list_valid[v] && budget != 0) begin
          list_push(req, list_pop(v));
          budget--;
        end
      end
    end
    if (!list_valid[req]) begin
      res.status = pcpa_pkg::ST_OOM;
    end else begin
      res.addr   = base + ({17'd0, list_pop(req)} << pcpa_pkg::PG_SHIFT);
      res.status = pcpa_pkg::ST_ALLOC;
    end
    return res;
  endfunction

  // Send one transaction; start stays high after acceptance.
  task automatic send_op(input logic act, input logic [pcpa_pkg::REQ_W-1:0] req,
                         input logic [pcpa_pkg::ADDR_W-1:0] addr);
    start        <= 1'b1;
    in_action    <= act;
    in_requester <= req;
    in_page_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_page_op(act, req, addr));
  endtask

  // Insert a random gap between bursts of back-to-back transactions.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
    if (gap == 0) return;
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_paced(input logic act, input logic [pcpa_pkg::REQ_W-1:0] req,
                            input logic [pcpa_pkg::ADDR_W-1:0] addr);
    send_op(act, req, addr);
    pace_sender();
  endtask

  // Drain outstanding results, then write both region registers.
  task automatic set_region(input logic [pcpa_pkg::ADDR_W-1:0] lo,
                            input logic [pcpa_pkg::ADDR_W-1:0] hi);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= pcpa_pkg::CFG_REGION_START;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= pcpa_pkg::CFG_REGION_END;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    region_lo = lo;
    region_hi = hi;
  endtask

  // Every list empty after reset and a zero-size region rejects all frees.
  task automatic test_empty_lists();
    send_op(pcpa_pkg::ACT_ALLOC, 3'd0, 32'h0);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_op(pcpa_pkg::ACT_FREE, 3'd0, 32'h0);
    send_op(pcpa_pkg::ACT_FREE, 3'd7, 32'hFFFF_F000);
  endtask

  // Region bounds, alignment and capacity checks on free.
  task automatic test_free_bounds();
    set_region(32'h0000_1001, 32'h0801_0000);
    send_op(pcpa_pkg::ACT_FREE, 3'd1, 32'h0000_1000);  // below start
    send_op(pcpa_pkg::ACT_FREE, 3'd1, 32'h0000_2000);  // first page
    send_op(pcpa_pkg::ACT_FREE, 3'd1, 32'h0000_2800);  // misaligned
    send_op(pcpa_pkg::ACT_FREE, 3'd2, 32'h0800_2000);  // beyond capacity
    send_op(pcpa_pkg::ACT_FREE, 3'd2, 32'h0800_1000);  // last page
    send_op(pcpa_pkg::ACT_FREE, 3'd2, 32'h0801_0000);  // at end
    send_op(pcpa_pkg::ACT_ALLOC, 3'd2, 32'h1234_5678);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd1, 32'h0);
  endtask

  // Empty requester steals from lower and higher indexes, more than the limit.
  task automatic test_steal();
    set_region(32'h0010_0000, 32'h0020_0000);
    for (int i = 0; i < 40; i++)
      send_op(pcpa_pkg::ACT_FREE, 3'd2, 32'h0010_0000 + i * 4096);
    for (int i = 0; i < 40; i++)
      send_op(pcpa_pkg::ACT_FREE, 3'd6, 32'h0018_0000 + i * 4096);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd4, 32'h0);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd6, 32'h0);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd2, 32'h0);
  endtask

  // Page zero allocates with a good status when the region starts at zero.
  task automatic test_address_zero();
    set_region(32'h0, 32'hFFFF_FFFF);
    send_op(pcpa_pkg::ACT_FREE, 3'd3, 32'h0);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd3, 32'h0);
    send_op(pcpa_pkg::ACT_ALLOC, 3'd3, 32'h0);
  endtask

  // Random transactions, mostly valid frees and allocs within the region.
  task automatic test_random_ops(input logic [pcpa_pkg::ADDR_W-1:0] lo,
                                 input logic [pcpa_pkg::ADDR_W-1:0] hi, input int count);
    logic [pcpa_pkg::ADDR_W-1:0] base;
    logic [pcpa_pkg::ADDR_W-1:0] addr;
    int                          sel;
    set_region(lo, hi);
    base = (lo + 32'hFFF) & ~32'hFFF;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_paced(pcpa_pkg::ACT_ALLOC, $urandom_range(0, 7), $urandom);
      end else begin
        if (sel < 85) addr = base + $urandom_range(0, 70) * 4096;
        else if (sel < 92) addr = base - 4096 * $urandom_range(0, 2);
        else addr = $urandom;
        send_paced(pcpa_pkg::ACT_FREE, $urandom_range(0, 7), addr);
      end
    end
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr %h status %0d", $time,
                 out_result_addr, out_status);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result_addr !== exp_res.addr) begin
          $display("%0t: result_addr expected %h actual %h", $time,
                   exp_res.addr, out_result_addr);
          error_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= pcpa_pkg::CFG_REGION_START;
    cfg_wdata    <= '0;
    start        <= 1'b0;
    in_action    <= pcpa_pkg::ACT_ALLOC;
    in_requester <= '0;
    in_page_addr <= '0;
    burst_left   = 0;
    region_lo    = '0;
    region_hi    = '0;
    for (int r = 0; r < pcpa_pkg::NUM_REQ; r++) begin
      list_valid[r] = 1'b0;
      head_page[r]  = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_lists();
    test_free_bounds();
    test_steal();
    test_address_zero();
    test_random_ops(32'h0004_0000, 32'h0008_0000, 190);
    test_random_ops(32'h0000_3007, 32'h0004_5000, 190);
    test_random_ops(32'hFFFB_0000, 32'hFFFF_FFFF, 190);
    test_random_ops(32'h0, 32'h0, 40);
    test_random_ops(32'h07FF_C000, 32'hFFFF_FFFF, 150);

    // Drain, with a bound on the wait.
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < WATCHDOG_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
